// ===== hw/rtl/atsrs_pkg.sv =====
package atsrs_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned WAIT_W   = 13;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND  = 2'd2;

  // register reset values
  localparam logic                HALF_STEP_RST = 1'b1;
  localparam logic [SAMPLE_W-1:0] CENTER_RST    = 12'd2047;
  localparam logic [SAMPLE_W-1:0] DEADBAND_RST  = 12'd50;

  // divider runs one quotient bit per cycle
  localparam logic [CNT_W-1:0]  DIV_LAST  = 4'(SAMPLE_W - 1);
  localparam logic [WAIT_W-1:0] WAIT_BASE = 13'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_DIV   = 4'b0100,
    S_FIN   = 4'b1000
  } atsrs_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic finish;
  } atsrs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic no_step;
    logic div_last;
    logic out_free;
  } atsrs_sts_t;

  // eight-phase half-step coil table
  function automatic logic [COIL_W-1:0] half_pattern(input logic [PHASE_W-1:0] ph);
    logic [COIL_W-1:0] p;
    unique case (ph)
      3'd0: p = 4'h1;
      3'd1: p = 4'h3;
      3'd2: p = 4'h2;
      3'd3: p = 4'h6;
      3'd4: p = 4'h4;
      3'd5: p = 4'hC;
      3'd6: p = 4'h8;
      3'd7: p = 4'h9;
      default: p = 4'h1;
    endcase
    return p;
  endfunction

  // four-phase full-step coil table
  function automatic logic [COIL_W-1:0] full_pattern(input logic [1:0] ph);
    logic [COIL_W-1:0] p;
    unique case (ph)
      2'd0: p = 4'h3;
      2'd1: p = 4'h6;
      2'd2: p = 4'hC;
      2'd3: p = 4'h9;
      default: p = 4'h3;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/analog_to_stepper_rate_sequencer.sv =====
// channel | ports                         | payload
// in      | in_tvalid/in_tready/in_tdata  | adc_sample
// out     | out_tvalid/out_tready/out_tdata | stepped, moved_forward, coil_pattern, wait_ticks
// cfg     | cfg_valid/cfg_ready/cfg_index/cfg_data | half_step_mode, center_value, deadband
//
// a stepping sample passes these steps from acceptance to the next acceptance:
// capture, step setup, 12 iterations of the 1-bit restoring divider, result load
// a sample inside the deadband skips the divider pass
// rst_n is synchronous: phase clears to 0, registers take their defaults
// a stalled output holds the block in its last state until the result is taken
// cfg writes are always accepted; write only while the block is idle
module analog_to_stepper_rate_sequencer
  import atsrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [11:0] adc_sample, [15:12] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] stepped, [1] moved_forward,
                                             // [5:2] coil_pattern, [18:6] wait_ticks
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SAMPLE_W-1:0]    cfg_data
);

  logic                half_step_r;
  logic [SAMPLE_W-1:0] center_r;
  logic [SAMPLE_W-1:0] deadband_r;
  atsrs_cmd_t          cmd;
  atsrs_sts_t          sts;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_step_r <= HALF_STEP_RST;
      center_r    <= CENTER_RST;
      deadband_r  <= DEADBAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HALF_STEP: half_step_r <= cfg_data[0];
        REG_CENTER:    center_r    <= cfg_data;
        REG_DEADBAND:  deadband_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // controller
  atsrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  atsrs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .half_step_mode (half_step_r),
    .center_value   (center_r),
    .deadband       (deadband_r),
    .adc_sample     (in_tdata[SAMPLE_W-1:0]),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

// ===== hw/rtl/atsrs_ctrl.sv =====
module atsrs_ctrl
  import atsrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  atsrs_sts_t sts,
  output atsrs_cmd_t cmd
);

  atsrs_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.no_step ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/atsrs_dp.sv =====
module atsrs_dp
  import atsrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   half_step_mode,
  input  logic [SAMPLE_W-1:0]    center_value,
  input  logic [SAMPLE_W-1:0]    deadband,
  input  logic [SAMPLE_W-1:0]    adc_sample,
  input  atsrs_cmd_t             cmd,
  output atsrs_sts_t             sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [SAMPLE_W-1:0]    speed_r;
  logic                   fwd_r;
  logic                   step_r;
  logic [PHASE_W-1:0]     phase_r;
  logic [COIL_W-1:0]      coil_r;
  logic [SAMPLE_W-1:0]    rem_r;
  logic [SAMPLE_W-1:0]    quo_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                   fwd;
  logic [SAMPLE_W-1:0]    speed;
  logic [PHASE_W-1:0]     phase_nxt;
  logic [1:0]             full_ph;
  logic [COIL_W-1:0]      coil_nxt;
  logic [SAMPLE_W:0]      rem_sh;
  logic                   rem_ge;
  logic [SAMPLE_W-1:0]    rem_nxt;
  logic [WAIT_W-1:0]      wait_ticks;
  logic [OUT_TDATA_W-1:0] result;

  // direction and distance from centre
  assign fwd   = adc_sample > center_value;
  assign speed = fwd ? (adc_sample - center_value) : (center_value - adc_sample);

  // next phase and coil pattern
  assign full_ph = fwd_r ? (phase_r[1:0] + 2'd1) : (phase_r[1:0] - 2'd1);
  always_comb begin
    if (half_step_mode) begin
      phase_nxt = fwd_r ? (phase_r + 3'd1) : (phase_r - 3'd1);
      coil_nxt  = half_pattern(phase_nxt);
    end else begin
      phase_nxt = {1'b0, full_ph};
      coil_nxt  = full_pattern(full_ph);
    end
  end

  // restoring divider step
  assign rem_sh  = {rem_r, quo_r[SAMPLE_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, speed_r};
  assign rem_nxt = rem_ge ? SAMPLE_W'(rem_sh - {1'b0, speed_r}) : rem_sh[SAMPLE_W-1:0];

  // result packing
  assign wait_ticks = WAIT_W'(quo_r) + WAIT_BASE;
  assign result = step_r ? {5'd0, wait_ticks, coil_r, fwd_r, 1'b1} : '0;

  // status to controller
  assign sts.no_step  = speed_r <= deadband;
  assign sts.div_last = cnt_r == DIV_LAST;
  assign sts.out_free = !out_valid_r || out_tready;

  // phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.setup && !sts.no_step) begin
      phase_r <= phase_nxt;
    end
  end

  // sample capture, step setup and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed_r <= speed;
      fwd_r   <= fwd;
    end
    if (cmd.setup) begin
      step_r <= !sts.no_step;
      coil_r <= coil_nxt;
      rem_r  <= '0;
      quo_r  <= center_value;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SAMPLE_W-2:0], rem_ge};
      cnt_r <= cnt_r + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/atsrs_chk.sv =====
module atsrs_chk
  import atsrs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [SAMPLE_W-1:0]    cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one sample at a time: busy right after an accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous sample in progress");

  // no-step results carry all zeros
  a_no_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[18:1] == 18'd0)
    else $error("no-step result not cleared");

  // a step drives some coil and waits at least the base ticks
  a_step_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[5:2] != 4'd0 && out_tdata[18:6] >= WAIT_BASE)
    else $error("step result malformed");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind analog_to_stepper_rate_sequencer atsrs_chk u_atsrs_chk (.*);
